// ===== design/ordered_slot_list_engine_macros.svh =====
`ifndef ORDERED_SLOT_LIST_ENGINE_MACROS_SVH
`define ORDERED_SLOT_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define OSLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define OSLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/osle_pkg.sv =====
package osle_pkg;

    localparam int SLOTS        = 12;
    localparam int HANDLE_WIDTH = 16;
    localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W        = $clog2(SLOTS + 1);

    localparam int MODE_W   = 3;
    localparam int FIELD_W  = 16;
    localparam int SEL_W    = 4;

    localparam logic [MODE_W-1:0] MODE_APPEND     = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_REMOVE     = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_MOVE_FRONT = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_MOVE_BACK  = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_READ       = MODE_W'(4);

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] item_handle;
        logic [SEL_W-1:0]   slot_select;
    } osle_req_t;

    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] slot_value;
    } osle_rsp_t;

    typedef struct packed {
        logic                    en;
        logic [IDX_W-1:0]        idx;
        logic [HANDLE_WIDTH-1:0] data;
    } osle_wr_t;

    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] from;
    } osle_clr_t;

endpackage

// ===== design/osle_slot_bank.sv =====
module osle_slot_bank (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [osle_pkg::IDX_W-1:0]       rd_idx,
    output logic [osle_pkg::HANDLE_WIDTH-1:0] rd_data,
    input  osle_pkg::osle_wr_t               wr,
    input  osle_pkg::osle_clr_t              clr
);
    import osle_pkg::*;

    logic [HANDLE_WIDTH-1:0] slot_reg  [SLOTS];
    logic [HANDLE_WIDTH-1:0] slot_next [SLOTS];

    assign rd_data = (32'(rd_idx) < SLOTS) ? slot_reg[rd_idx] : '0;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (clr.en && (CNT_W'(i) >= clr.from))
            begin
                slot_next[i] = '0;
            end
            else if (wr.en && (wr.idx == IDX_W'(i)))
            begin
                slot_next[i] = wr.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

endmodule

// ===== design/ordered_slot_list_engine.sv =====
// Ordered list of SLOTS handles with append, remove-all, move-to-front, move-to-back
// and slot read. One request is in progress at a time; req_stall is high from the
// cycle after acceptance until the sequencer has finished. A single slot read port
// and one comparator step through the list one slot per cycle. A read or a rejected
// request goes straight to the result; append scans for the first empty slot and
// the moves for the first match of the handle, after which a move shifts entries;
// remove-all scans the whole list, compacts the kept entries and clears the tail.
// The result sits in an output register, so a new request may be accepted while
// the previous result is still stalled.
`include "ordered_slot_list_engine_macros.svh"

module ordered_slot_list_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  osle_pkg::osle_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output osle_pkg::osle_rsp_t rsp
);
    import osle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FRONT,
        S_BACK,
        S_REMOVE,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [MODE_W-1:0]       op_reg, op_next;
    logic [HANDLE_WIDTH-1:0] key_reg, key_next;
    logic [CNT_W-1:0]        ptr_reg, ptr_next;
    logic [CNT_W-1:0]        wr_reg, wr_next;
    logic [IDX_W-1:0]        hit_reg, hit_next;
    logic [HANDLE_WIDTH-1:0] hold_reg, hold_next;
    logic                    ok_reg, ok_next;
    logic [FIELD_W-1:0]      val_reg, val_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    osle_rsp_t               rsp_reg, rsp_next;

    logic [HANDLE_WIDTH-1:0] req_handle;
    logic                    sel_ok;
    logic [IDX_W-1:0]        ptr_idx;
    logic [IDX_W-1:0]        back_idx;
    logic                    ptr_end;
    logic [IDX_W-1:0]        rd_idx;
    logic [HANDLE_WIDTH-1:0] rd_data;
    logic [HANDLE_WIDTH-1:0] cmp_key;
    logic                    match;
    logic                    rsp_free;
    osle_wr_t                wr;
    osle_clr_t               clr;

    osle_slot_bank u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr      (wr),
        .clr     (clr)
    );

    assign req_handle = HANDLE_WIDTH'(req.item_handle);
    assign sel_ok     = 32'(req.slot_select) < SLOTS;
    assign ptr_idx    = ptr_reg[IDX_W-1:0];
    assign back_idx   = IDX_W'(ptr_reg - CNT_W'(1));
    assign ptr_end    = ptr_reg == CNT_W'(SLOTS);
    assign rd_idx     = (state_reg == S_IDLE) ? IDX_W'(req.slot_select) : ptr_idx;
    assign cmp_key    = (((state_reg == S_SCAN) && (op_reg == MODE_APPEND))
                         || (state_reg == S_BACK)) ? '0 : key_reg;
    assign match      = rd_data == cmp_key;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign req_stall  = state_reg != S_IDLE;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        ptr_next       = ptr_reg;
        wr_next        = wr_reg;
        hit_next       = hit_reg;
        hold_next      = hold_reg;
        ok_next        = ok_reg;
        val_next       = val_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        wr             = '0;
        clr            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = req.mode;
                    key_next = req_handle;
                    ptr_next = '0;
                    wr_next  = '0;
                    ok_next  = 1'b0;
                    val_next = '0;
                    if (req.mode == MODE_READ)
                    begin
                        if (sel_ok)
                        begin
                            ok_next  = 1'b1;
                            val_next = FIELD_W'(rd_data);
                        end
                        state_next = S_DONE;
                    end
                    else if ((req.mode <= MODE_MOVE_BACK) && (req_handle != '0))
                    begin
                        state_next = (req.mode == MODE_REMOVE) ? S_REMOVE : S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (ptr_end)
                begin
                    state_next = S_DONE;
                end
                else if (match)
                begin
                    if (op_reg == MODE_APPEND)
                    begin
                        wr         = '{en: 1'b1, idx: ptr_idx, data: key_reg};
                        ok_next    = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (op_reg == MODE_MOVE_FRONT)
                    begin
                        hit_next   = ptr_idx;
                        ptr_next   = '0;
                        hold_next  = key_reg;
                        state_next = S_FRONT;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + CNT_W'(1);
                        state_next = S_BACK;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            S_FRONT:
            begin
                wr        = '{en: 1'b1, idx: ptr_idx, data: hold_reg};
                hold_next = rd_data;
                if (ptr_idx == hit_reg)
                begin
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            S_BACK:
            begin
                if (ptr_end || match)
                begin
                    wr         = '{en: 1'b1, idx: back_idx, data: key_reg};
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    wr       = '{en: 1'b1, idx: back_idx, data: rd_data};
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            S_REMOVE:
            begin
                if (ptr_end)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    if (match)
                    begin
                        ok_next = 1'b1;
                    end
                    else
                    begin
                        wr      = '{en: 1'b1, idx: wr_reg[IDX_W-1:0], data: rd_data};
                        wr_next = wr_reg + CNT_W'(1);
                    end
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            S_CLEAR:
            begin
                clr        = '{en: 1'b1, from: wr_reg};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if ((state_reg == S_DONE) && rsp_free)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '{ok: ok_reg, slot_value: val_reg};
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            key_reg       <= '0;
            ptr_reg       <= '0;
            wr_reg        <= '0;
            hit_reg       <= '0;
            hold_reg      <= '0;
            ok_reg        <= 1'b0;
            val_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            key_reg       <= key_next;
            ptr_reg       <= ptr_next;
            wr_reg        <= wr_next;
            hit_reg       <= hit_next;
            hold_reg      <= hold_next;
            ok_reg        <= ok_next;
            val_reg       <= val_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    `OSLE_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted item did not block the request side")
    `OSLE_ASSERT_NOW(a_fail_no_value, rsp_valid && !rsp.ok, rsp.slot_value == '0, "failed item carries a slot value")
    `OSLE_ASSERT_NOW(a_write_in_range, wr.en, 32'(wr.idx) < SLOTS, "slot write outside the list")
    `OSLE_ASSERT_NOW(a_ptr_bound, 1'b1, (ptr_reg <= CNT_W'(SLOTS)) && (wr_reg <= ptr_reg), "scan pointers out of order")

endmodule
